// ===== design/touch_sample_qualify_and_map_macros.svh =====
// Assertion helpers used by the top module touch_sample_qualify_and_map
`ifndef TOUCH_SAMPLE_QUALIFY_AND_MAP_MACROS_SVH
`define TOUCH_SAMPLE_QUALIFY_AND_MAP_MACROS_SVH

// Immediate implication checked at every clock edge outside reset
`define TSQM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define TSQM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tsqm_pkg.sv =====
// ---------------------------------------------------------------------------
// tsqm_pkg
// Shared types, widths and status codes of the touch qualifier and mapper.
// ---------------------------------------------------------------------------
`default_nettype none

package tsqm_pkg;

  localparam int RAW_W  = 12;
  localparam int PRES_W = 13;
  localparam int NUM_W  = 21;   // |raw diff| * |screen span| magnitude
  localparam int SX_W   = 9;
  localparam int SY_W   = 8;
  localparam int ST_W   = 3;

  localparam logic [SX_W-1:0] SCREEN_X_MAX = 9'd319;
  localparam logic [SX_W-1:0] SCREEN_Y_MAX = 9'd239;
  localparam logic [PRES_W-1:0] PRES_OFFSET = 13'd4096;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_PRESS = 3'd1;
  localparam logic [ST_W-1:0] ST_RELEASED = 3'd2;
  localparam logic [ST_W-1:0] ST_JITTER   = 3'd3;
  localparam logic [ST_W-1:0] ST_WINDOW   = 3'd4;
  localparam logic [ST_W-1:0] ST_UNCAL    = 3'd5;

  // Register indexes
  localparam logic [2:0] REG_PRESSURE_MIN = 3'd0;
  localparam logic [2:0] REG_MAX_JITTER   = 3'd1;
  localparam logic [2:0] REG_CAL_A0       = 3'd2;
  localparam logic [2:0] REG_CAL_A1       = 3'd3;
  localparam logic [2:0] REG_CAL_B0       = 3'd4;
  localparam logic [2:0] REG_CAL_B1       = 3'd5;
  localparam logic [2:0] REG_SWAP_AXES    = 3'd6;
  localparam logic [2:0] REG_CAL_VALID    = 3'd7;

  typedef struct packed {
    logic [RAW_W-1:0] first_z1;
    logic [RAW_W-1:0] first_z2;
    logic [RAW_W-1:0] x_first;
    logic [RAW_W-1:0] y_first;
    logic [RAW_W-1:0] second_z1;
    logic [RAW_W-1:0] second_z2;
    logic [RAW_W-1:0] x_second;
    logic [RAW_W-1:0] y_second;
  } sample_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic [SX_W-1:0]  screen_x;
    logic [SY_W-1:0]  screen_y;
  } result_t;

  typedef struct packed {
    logic [PRES_W-1:0] pressure_min;
    logic [RAW_W-1:0]  max_jitter;
    logic [RAW_W-1:0]  cal_a0;
    logic [RAW_W-1:0]  cal_a1;
    logic [RAW_W-1:0]  cal_b0;
    logic [RAW_W-1:0]  cal_b1;
    logic              swap_axes;
    logic              cal_valid;
  } cfg_t;

  // Qualified item after the first stage
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic [RAW_W-1:0] ra;
    logic [RAW_W-1:0] rb;
  } qual_t;

  // Data carried alongside the X divider
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic             neg;
  } xside_t;

  // Apply sign to the quotient, add the screen origin, clamp to 0..smax
  function automatic logic [SX_W-1:0] map_clamp(input logic neg,
                                                input logic [NUM_W-1:0] q,
                                                input logic [SX_W-1:0] s0,
                                                input logic [SX_W-1:0] smax);
    logic [NUM_W:0] sum;
    logic [NUM_W:0] dif;
    begin
      sum = {1'b0, q} + {{(NUM_W+1-SX_W){1'b0}}, s0};
      dif = {{(NUM_W+1-SX_W){1'b0}}, s0} - {1'b0, q};
      if (neg) begin
        map_clamp = ({1'b0, q} > {{(NUM_W+1-SX_W){1'b0}}, s0}) ? '0 : dif[SX_W-1:0];
      end else begin
        map_clamp = (sum > {{(NUM_W+1-SX_W){1'b0}}, smax}) ? smax : sum[SX_W-1:0];
      end
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/touch_sample_qualify_and_map.sv =====
// ---------------------------------------------------------------------------
// touch_sample_qualify_and_map
// Qualifies one round of resistive touch readings and maps it to screen.
// ---------------------------------------------------------------------------
// One item per clock while no result is held; every item gives exactly one result
// after qualify, multiply, 21 bit-per-stage calibration divider stages, and map
// and clamp. The whole pipeline holds while a result waits under result_stall.
`default_nettype none

module touch_sample_qualify_and_map #(
  parameter int CAL_SCREEN_X0  = 50,
  parameter int CAL_SCREEN_X1  = 270,
  parameter int CAL_SCREEN_Y0  = 50,
  parameter int CAL_SCREEN_Y1  = 190,
  parameter int RAW_WINDOW_MIN = 100,
  parameter int RAW_WINDOW_MAX = 4000
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                sample_valid,
  output logic                     sample_stall,
  input  wire tsqm_pkg::sample_t   sample,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output tsqm_pkg::result_t        result,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [tsqm_pkg::PRES_W-1:0] cfg_data
);

  `include "touch_sample_qualify_and_map_macros.svh"

  localparam int DSX = CAL_SCREEN_X1 - CAL_SCREEN_X0;
  localparam int DSY = CAL_SCREEN_Y1 - CAL_SCREEN_Y0;
  localparam logic [tsqm_pkg::SX_W-1:0] DSX_MAG = tsqm_pkg::SX_W'((DSX < 0) ? -DSX : DSX);
  localparam logic [tsqm_pkg::SX_W-1:0] DSY_MAG = tsqm_pkg::SX_W'((DSY < 0) ? -DSY : DSY);
  localparam logic DSX_NEG = (DSX < 0);
  localparam logic DSY_NEG = (DSY < 0);
  localparam logic [tsqm_pkg::SX_W-1:0] SX0 = tsqm_pkg::SX_W'(CAL_SCREEN_X0);
  localparam logic [tsqm_pkg::SX_W-1:0] SY0 = tsqm_pkg::SX_W'(CAL_SCREEN_Y0);

  localparam int XSIDE_W = $bits(tsqm_pkg::xside_t);

  tsqm_pkg::cfg_t cfg;
  logic           en;

  // Pipeline advances unless a result is held
  assign en           = !(result_valid && result_stall);
  assign sample_stall = !en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pressure_min <= 13'd80;
      cfg.max_jitter   <= 12'd150;
      cfg.cal_a0       <= '0;
      cfg.cal_a1       <= '0;
      cfg.cal_b0       <= '0;
      cfg.cal_b1       <= '0;
      cfg.swap_axes    <= 1'b0;
      cfg.cal_valid    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        tsqm_pkg::REG_PRESSURE_MIN: cfg.pressure_min <= cfg_data;
        tsqm_pkg::REG_MAX_JITTER:   cfg.max_jitter   <= cfg_data[tsqm_pkg::RAW_W-1:0];
        tsqm_pkg::REG_CAL_A0:       cfg.cal_a0       <= cfg_data[tsqm_pkg::RAW_W-1:0];
        tsqm_pkg::REG_CAL_A1:       cfg.cal_a1       <= cfg_data[tsqm_pkg::RAW_W-1:0];
        tsqm_pkg::REG_CAL_B0:       cfg.cal_b0       <= cfg_data[tsqm_pkg::RAW_W-1:0];
        tsqm_pkg::REG_CAL_B1:       cfg.cal_b1       <= cfg_data[tsqm_pkg::RAW_W-1:0];
        tsqm_pkg::REG_SWAP_AXES:    cfg.swap_axes    <= cfg_data[0];
        tsqm_pkg::REG_CAL_VALID:    cfg.cal_valid    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage 1: qualification
  logic            q_valid;
  tsqm_pkg::qual_t q_item;

  tsqm_qualify #(
    .RAW_WINDOW_MIN(RAW_WINDOW_MIN),
    .RAW_WINDOW_MAX(RAW_WINDOW_MAX)
  ) u_qualify (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_valid(sample_valid),
    .in_item (sample),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  // Divisor magnitudes, signs; user keeps them stable while items in flight
  logic                       den_x_neg, den_y_neg;
  logic [tsqm_pkg::RAW_W-1:0] den_x, den_y;
  assign den_x_neg = cfg.cal_a1 < cfg.cal_a0;
  assign den_y_neg = cfg.cal_b1 < cfg.cal_b0;
  assign den_x = den_x_neg ? cfg.cal_a0 - cfg.cal_a1 : cfg.cal_a1 - cfg.cal_a0;
  assign den_y = den_y_neg ? cfg.cal_b0 - cfg.cal_b1 : cfg.cal_b1 - cfg.cal_b0;

  // Stage 2: offset from first calibration point times screen span
  logic                       dx_neg, dy_neg;
  logic [tsqm_pkg::RAW_W-1:0] dx_mag, dy_mag;
  assign dx_neg = q_item.ra < cfg.cal_a0;
  assign dy_neg = q_item.rb < cfg.cal_b0;
  assign dx_mag = dx_neg ? cfg.cal_a0 - q_item.ra : q_item.ra - cfg.cal_a0;
  assign dy_mag = dy_neg ? cfg.cal_b0 - q_item.rb : q_item.rb - cfg.cal_b0;

  // Operands widened to the full product width
  logic [tsqm_pkg::NUM_W-1:0] dx_ext, dy_ext, dsx_ext, dsy_ext;
  assign dx_ext  = {{(tsqm_pkg::NUM_W-tsqm_pkg::RAW_W){1'b0}}, dx_mag};
  assign dy_ext  = {{(tsqm_pkg::NUM_W-tsqm_pkg::RAW_W){1'b0}}, dy_mag};
  assign dsx_ext = {{(tsqm_pkg::NUM_W-tsqm_pkg::SX_W){1'b0}}, DSX_MAG};
  assign dsy_ext = {{(tsqm_pkg::NUM_W-tsqm_pkg::SX_W){1'b0}}, DSY_MAG};

  logic                       m_valid;
  logic [tsqm_pkg::NUM_W-1:0] m_nx, m_ny;
  tsqm_pkg::xside_t           m_xside;
  logic                       m_ny_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_nx           <= dx_ext * dsx_ext;
      m_ny           <= dy_ext * dsy_ext;
      m_xside.status <= q_item.status;
      m_xside.raw_x  <= q_item.raw_x;
      m_xside.raw_y  <= q_item.raw_y;
      m_xside.neg    <= dx_neg ^ DSX_NEG ^ den_x_neg;
      m_ny_neg       <= dy_neg ^ DSY_NEG ^ den_y_neg;
    end
  end

  // Stages 3..23: dividers
  logic                       dx_valid, dy_valid, dy_neg_o;
  logic [tsqm_pkg::NUM_W-1:0] qx, qy;
  tsqm_pkg::xside_t           d_xside;

  tsqm_div #(
    .W     (tsqm_pkg::NUM_W),
    .DW    (tsqm_pkg::RAW_W),
    .SIDE_W(XSIDE_W)
  ) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (m_valid),
    .num      (m_nx),
    .den      (den_x),
    .side_in  (m_xside),
    .out_valid(dx_valid),
    .quot     (qx),
    .side_out (d_xside)
  );

  tsqm_div #(
    .W     (tsqm_pkg::NUM_W),
    .DW    (tsqm_pkg::RAW_W),
    .SIDE_W(1)
  ) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (m_valid),
    .num      (m_ny),
    .den      (den_y),
    .side_in  (m_ny_neg),
    .out_valid(dy_valid),
    .quot     (qy),
    .side_out (dy_neg_o)
  );

  // Final stage: map, clamp, output register
  logic [tsqm_pkg::SX_W-1:0] sx_map, sy_map;
  assign sx_map = tsqm_pkg::map_clamp(d_xside.neg, qx, SX0, tsqm_pkg::SCREEN_X_MAX);
  assign sy_map = tsqm_pkg::map_clamp(dy_neg_o, qy, SY0, tsqm_pkg::SCREEN_Y_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= dx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.status <= d_xside.status;
      result.raw_x  <= d_xside.raw_x;
      result.raw_y  <= d_xside.raw_y;
      if (d_xside.status == tsqm_pkg::ST_OK) begin
        result.screen_x <= sx_map;
        result.screen_y <= sy_map[tsqm_pkg::SY_W-1:0];
      end else begin
        result.screen_x <= '0;
        result.screen_y <= '0;
      end
    end
  end

  // Checks
  `TSQM_ASSERT_IMP(a_div_lanes_aligned, 1'b1, dx_valid == dy_valid,
    "divider lanes out of step")
  `TSQM_ASSERT_IMP(a_screen_zero_on_error,
    result_valid && result.status != tsqm_pkg::ST_OK,
    result.screen_x == '0 && result.screen_y == '0, "screen set on failed item")
  `TSQM_ASSERT_IMP(a_raw_zero_on_reject,
    result_valid && result.status != tsqm_pkg::ST_OK && result.status != tsqm_pkg::ST_UNCAL,
    result.raw_x == '0 && result.raw_y == '0, "raw set on rejected item")
  `TSQM_ASSERT_IMP(a_screen_in_range, result_valid,
    result.screen_x <= tsqm_pkg::SCREEN_X_MAX &&
    {1'b0, result.screen_y} <= tsqm_pkg::SCREEN_Y_MAX,
    "screen coordinate out of range")
  `TSQM_ASSERT_NEXT(a_hold_keeps_pipe, result_valid && result_stall,
    $stable(dx_valid) && $stable(m_valid), "pipeline moved while held")

endmodule

`default_nettype wire

// ===== design/tsqm_qualify.sv =====
// ---------------------------------------------------------------------------
// tsqm_qualify
// First stage: pressure, jitter, window and calibration checks, averages, axis select.
// ---------------------------------------------------------------------------
`default_nettype none

module tsqm_qualify #(
  parameter int RAW_WINDOW_MIN = 100,
  parameter int RAW_WINDOW_MAX = 4000
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire tsqm_pkg::sample_t in_item,
  input  wire tsqm_pkg::cfg_t    cfg,
  output logic                  q_valid,
  output tsqm_pkg::qual_t       q_item
);

  localparam logic [tsqm_pkg::RAW_W-1:0] WMIN = tsqm_pkg::RAW_W'(RAW_WINDOW_MIN);
  localparam logic [tsqm_pkg::RAW_W-1:0] WMAX = tsqm_pkg::RAW_W'(RAW_WINDOW_MAX);

  logic [tsqm_pkg::PRES_W-1:0] p1, p2;
  logic [tsqm_pkg::RAW_W-1:0]  jx, jy, ax, ay;
  logic [tsqm_pkg::RAW_W:0]    sx, sy;
  tsqm_pkg::qual_t             q_next;

  // Pressure never goes below one, so no clamp is needed
  assign p1 = {1'b0, in_item.first_z1} + tsqm_pkg::PRES_OFFSET
              - {1'b0, in_item.first_z2};
  assign p2 = {1'b0, in_item.second_z1} + tsqm_pkg::PRES_OFFSET
              - {1'b0, in_item.second_z2};

  assign jx = (in_item.x_first > in_item.x_second) ?
              in_item.x_first - in_item.x_second : in_item.x_second - in_item.x_first;
  assign jy = (in_item.y_first > in_item.y_second) ?
              in_item.y_first - in_item.y_second : in_item.y_second - in_item.y_first;

  assign sx = {1'b0, in_item.x_first} + {1'b0, in_item.x_second};
  assign sy = {1'b0, in_item.y_first} + {1'b0, in_item.y_second};
  assign ax = sx[tsqm_pkg::RAW_W:1];
  assign ay = sy[tsqm_pkg::RAW_W:1];

  // Checks in priority order
  always_comb begin
    q_next.raw_x  = '0;
    q_next.raw_y  = '0;
    q_next.ra     = cfg.swap_axes ? ay : ax;
    q_next.rb     = cfg.swap_axes ? ax : ay;
    if (p1 < cfg.pressure_min) begin
      q_next.status = tsqm_pkg::ST_NO_PRESS;
    end else if (p2 < cfg.pressure_min) begin
      q_next.status = tsqm_pkg::ST_RELEASED;
    end else if (jx > cfg.max_jitter || jy > cfg.max_jitter) begin
      q_next.status = tsqm_pkg::ST_JITTER;
    end else if (ax < WMIN || ax > WMAX || ay < WMIN || ay > WMAX) begin
      q_next.status = tsqm_pkg::ST_WINDOW;
    end else begin
      q_next.raw_x = ax;
      q_next.raw_y = ay;
      if (!cfg.cal_valid || cfg.cal_a1 == cfg.cal_a0 || cfg.cal_b1 == cfg.cal_b0) begin
        q_next.status = tsqm_pkg::ST_UNCAL;
      end else begin
        q_next.status = tsqm_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (en) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_item <= q_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/tsqm_div.sv =====
// ---------------------------------------------------------------------------
// tsqm_div
// Pipelined restoring divider: one quotient bit per stage, W stages.
// ---------------------------------------------------------------------------
`default_nettype none

module tsqm_div #(
  parameter int W      = 21,
  parameter int DW     = 12,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [W-1:0]      num,
  input  wire logic [DW-1:0]     den,
  input  wire logic [SIDE_W-1:0] side_in,
  output logic                   out_valid,
  output logic [W-1:0]           quot,
  output logic [SIDE_W-1:0]      side_out
);

  // Per stage: partial remainder, dividend shifted with quotient bits
  logic [W-1:0]      vld;
  logic [DW-1:0]     rem  [W];
  logic [W-1:0]      nq   [W];
  logic [SIDE_W-1:0] side [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [DW-1:0]     rem_prev;
    logic [W-1:0]      nq_prev;
    logic [SIDE_W-1:0] side_prev;
    logic              vld_prev;
    logic [DW:0]       trial;
    logic              fits;

    if (k == 0) begin : g_first
      assign rem_prev  = '0;
      assign nq_prev   = num;
      assign side_prev = side_in;
      assign vld_prev  = in_valid;
    end else begin : g_next
      assign rem_prev  = rem[k-1];
      assign nq_prev   = nq[k-1];
      assign side_prev = side[k-1];
      assign vld_prev  = vld[k-1];
    end

    assign trial = {rem_prev, nq_prev[W-1]};
    assign fits  = trial >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= fits ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
        nq[k]   <= {nq_prev[W-2:0], fits};
        side[k] <= side_prev;
      end
    end
  end

  assign out_valid = vld[W-1];
  assign quot      = nq[W-1];
  assign side_out  = side[W-1];

endmodule

`default_nettype wire
